// ===== src/etm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etm_pkg: shared types and constants of the exponential tone map pixel unit
// fixed-point formats, luminance weights, pipeline depths, payload structs
// ----------------------------------------------------------------------------
package etm_pkg;

    localparam int INPUT_FRAC_BITS = 16;
    localparam int OUTPUT_BITS     = 16;
    localparam int CHAN_W          = 32;
    localparam int CFG_W           = 32;
    localparam int LOG_FRAC        = 16;
    localparam int LUMA_FRAC       = 24;
    localparam int WEIGHT_W        = 24;
    localparam int LUMA_W          = CHAN_W + WEIGHT_W + 2;
    localparam int LOG_W           = 24;
    localparam int DIFF_W          = LOG_W + 1;
    localparam int T_W             = LOG_W + 3;
    localparam int GAMMA_FRAC      = 8;
    localparam int DIV_W           = T_W + GAMMA_FRAC - 1;
    localparam int CURVE_W         = 17;
    localparam int GAMMA_W         = 12;

    localparam int LOG_LAT         = LOG_FRAC + 2;
    localparam int DIV_LAT         = DIV_W + 2;
    localparam int EXP_LAT         = LOG_FRAC + 2;

    localparam logic [WEIGHT_W-1:0] W_RED   = 24'd3568046;
    localparam logic [WEIGHT_W-1:0] W_GREEN = 24'd11998405;
    localparam logic [WEIGHT_W-1:0] W_BLUE  = 24'd1210796;

    localparam logic [CURVE_W-1:0] CURVE_ONE = 17'd65536;

    localparam logic [CFG_W-1:0]   RST_EXPOSURE = 32'd65536;
    localparam logic [CFG_W-1:0]   RST_MAX_LUM  = 32'd65536;
    localparam logic [CURVE_W-1:0] RST_CURVE    = 17'd32768;
    localparam logic [GAMMA_W-1:0] RST_GAMMA    = 12'd563;

    typedef enum logic [1:0] {
        REG_EXPOSURE  = 2'd0,
        REG_MAX_LUM   = 2'd1,
        REG_CURVE_EXP = 2'd2,
        REG_GAMMA     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [OUTPUT_BITS-1:0] red_out;
        logic [OUTPUT_BITS-1:0] green_out;
        logic [OUTPUT_BITS-1:0] blue_out;
    } pixel_out_t;

    // flags that ride along the pipeline next to the data
    typedef struct packed {
        logic       valid;
        logic       black;
        logic [2:0] czero;
        logic [2:0] sat;
    } flags_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // 2^(2^-idx) in q1.31, each one the truncated square root of the previous
    function automatic logic [31:0] exp_factor(input int idx);
        logic [63:0] r;
        r = isqrt64(64'd1 << 63);
        for (int i = 1; i < idx; i++)
        begin
            r = isqrt64(r << 31);
        end
        return r[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/etm_delay.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etm_delay: flag shift line
// carries valid and per-pixel flags alongside a fixed-depth datapath
// ----------------------------------------------------------------------------
module etm_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);

    logic [W-1:0] stage_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                stage_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            stage_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign q = stage_reg[DEPTH-1];

endmodule
`default_nettype wire

// ===== src/etm_log2.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etm_log2: pipelined fixed-point log2
// leading-one stage, normalize stage, then one mantissa squaring per stage
// ----------------------------------------------------------------------------
module etm_log2 #(
    parameter int IN_W = 32,
    parameter int FRAC = 16
) (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic        [IN_W-1:0]          x,
    output logic signed      [etm_pkg::LOG_W-1:0] lg
);

    localparam int NW = $clog2(IN_W);
    localparam int LF = etm_pkg::LOG_FRAC;
    localparam int EW = etm_pkg::LOG_W - LF;

    logic [NW-1:0]   lead;
    logic [IN_W-1:0] x0_reg;
    logic [NW-1:0]   n0_reg;
    logic [31:0]     mant;

    logic [31:0]        m_reg [0:LF];
    logic [LF-1:0]      f_reg [0:LF];
    logic signed [EW-1:0] e_reg [0:LF];

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (x[i])
                lead = NW'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= x;
            n0_reg <= lead;
        end
    end

    always_comb
    begin
        if (n0_reg >= NW'(31))
            mant = 32'(x0_reg >> (n0_reg - NW'(31)));
        else
            mant = 32'(x0_reg << (NW'(31) - n0_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= mant;
            f_reg[0] <= '0;
            e_reg[0] <= EW'(int'(n0_reg) - FRAC);
        end
    end

    for (genvar s = 0; s < LF; s++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] half;

        assign sq   = {32'd0, m_reg[s]} * {32'd0, m_reg[s]};
        assign half = sq[63:31];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[s+1] <= half[32] ? half[32:1] : half[31:0];
                f_reg[s+1] <= {f_reg[s][LF-2:0], half[32]};
                e_reg[s+1] <= e_reg[s];
            end
        end
    end

    assign lg = {e_reg[LF], f_reg[LF]};

endmodule
`default_nettype wire

// ===== src/etm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etm_div: pipelined restoring divider
// gives ceil(-a / g) for a negative dividend, one quotient bit per stage
// ----------------------------------------------------------------------------
module etm_div #(
    parameter int DW = 34,
    parameter int GW = 12
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic signed [DW:0] a,
    input  wire logic [GW-1:0]     g,
    output logic      [DW-1:0]     um
);

    logic [GW-1:0] rem_reg [0:DW];
    logic [DW-1:0] q_reg   [0:DW];
    logic [DW-1:0] um_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0]   <= DW'(-a);
            rem_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < DW; i++)
    begin : g_step
        logic [GW:0] trial;
        logic [GW:0] diff;
        logic        ge;

        assign trial = {rem_reg[i], q_reg[i][DW-1]};
        assign ge    = trial >= {1'b0, g};
        assign diff  = trial - {1'b0, g};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? diff[GW-1:0] : trial[GW-1:0];
                q_reg[i+1]   <= {q_reg[i][DW-2:0], ge};
            end
        end
    end

    // round the magnitude up when anything is left over
    always_ff @(posedge clk)
    begin
        if (en)
            um_reg <= q_reg[DW] + DW'(rem_reg[DW] != '0);
    end

    assign um = um_reg;

endmodule
`default_nettype wire

// ===== src/etm_exp2.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etm_exp2: pipelined exp2 of a negative log-domain value
// split into integer and fraction, one constant factor per stage, final shift
// ----------------------------------------------------------------------------
module etm_exp2 #(
    parameter int DW = 34,
    parameter int OB = 16
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW-1:0] um,
    output logic      [OB-1:0] res
);

    localparam int LF   = etm_pkg::LOG_FRAC;
    localparam int KW   = DW + 1 - LF;
    localparam int KLIM = 33 + OB;
    localparam logic [DW:0]   ROUND = (DW+1)'((1 << LF) - 1);
    localparam logic [OB-1:0] MAXV  = '1;

    logic [DW:0]   up_sum;
    logic [KW-1:0] kc;
    logic [LF-1:0] f_next;

    logic [31:0]   m_reg  [0:LF];
    logic [LF-1:0] f_reg  [0:LF];
    logic [5:0]    sh_reg [0:LF];
    logic          z_reg  [0:LF];
    logic [31:0]   shifted;
    logic [OB-1:0] res_reg;

    assign up_sum = {1'b0, um} + ROUND;
    assign kc     = up_sum[DW:LF];
    assign f_next = -um[LF-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]  <= 32'h8000_0000;
            f_reg[0]  <= f_next;
            sh_reg[0] <= 6'(kc + KW'(31 - OB));
            z_reg[0]  <= kc >= KW'(KLIM);
        end
    end

    for (genvar s = 0; s < LF; s++)
    begin : g_mul
        localparam logic [31:0] FACT = etm_pkg::exp_factor(s + 1);
        logic [63:0] prod;

        assign prod = {32'd0, m_reg[s]} * {32'd0, FACT};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[s+1]  <= f_reg[s][LF-1-s] ? prod[62:31] : m_reg[s];
                f_reg[s+1]  <= f_reg[s];
                sh_reg[s+1] <= sh_reg[s];
                z_reg[s+1]  <= z_reg[s];
            end
        end
    end

    assign shifted = m_reg[LF] >> sh_reg[LF];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (z_reg[LF])
                res_reg <= '0;
            else if (shifted > 32'(MAXV))
                res_reg <= MAXV;
            else
                res_reg <= shifted[OB-1:0];
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// ===== src/exponential_tone_map_pixel_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// exponential_tone_map_pixel_unit: hdr to display tone mapping, one pixel per beat
// luminance, log2 lanes, tone curve, gamma divide and exp2 in a deep pipeline
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_stall with in_pixel (q16.16 red, green, blue)
//   out channel: out_valid / out_stall with out_pixel (q0.16 per color)
//   config: write_en, write_index, write_data set exposure, max luminance,
//   curve exponent and gamma; write them while no beat is in flight
// throughput: one beat per clock unless out_stall holds a finished beat at
//   the output; every stage advances together
// depth: the gamma divider (one quotient bit per stage, 36 stages with load
//   and round-up) and the 18-stage log2 and exp2 units set the pipeline depth
// reset: pipeline empties, out_valid low, registers take their defaults
// stall: when out_valid is high and out_stall is set, the whole pipe holds
//   and in_stall rises in the same cycle; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module exponential_tone_map_pixel_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              write_en,
    input  wire logic [1:0]                        write_index,
    input  wire logic [etm_pkg::CFG_W-1:0]         write_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire etm_pkg::pixel_in_t                in_pixel,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output etm_pkg::pixel_out_t                    out_pixel
);

    localparam int CW  = etm_pkg::CHAN_W;
    localparam int PW  = etm_pkg::CHAN_W + etm_pkg::WEIGHT_W;
    localparam int LW  = etm_pkg::LOG_W;
    localparam int DFW = etm_pkg::DIFF_W;
    localparam int TW  = etm_pkg::T_W;
    localparam int DW  = etm_pkg::DIV_W;
    localparam int OB  = etm_pkg::OUTPUT_BITS;
    localparam int FW  = $bits(etm_pkg::flags_t);
    localparam logic [OB-1:0] MAXV = '1;

    // configuration
    logic [etm_pkg::CFG_W-1:0]   exposure_reg;
    logic [etm_pkg::CFG_W-1:0]   max_lum_reg;
    logic [etm_pkg::CURVE_W-1:0] curve_reg;
    logic [etm_pkg::GAMMA_W-1:0] gamma_reg;
    logic [etm_pkg::CURVE_W-1:0] p_eff;
    logic [etm_pkg::GAMMA_W-1:0] g_eff;
    logic                        cfg_black;

    logic en;

    logic            valid_a_reg;
    logic [CW-1:0]   c_a_reg [0:2];
    logic [PW-1:0]   wp_a_reg [0:2];
    logic            valid_b_reg;
    logic [CW-1:0]   c_b_reg [0:2];
    logic [etm_pkg::LUMA_W-1:0] lum_reg;

    etm_pkg::flags_t flags_b;
    etm_pkg::flags_t flags_l;
    etm_pkg::flags_t flags_d_reg;
    etm_pkg::flags_t flags_p_reg;
    etm_pkg::flags_t flags_t_next;
    etm_pkg::flags_t flags_t_reg;
    etm_pkg::flags_t flags_z;

    logic signed [LW-1:0]  lg_l;
    logic signed [LW-1:0]  lg_max;
    logic signed [LW-1:0]  lg_c [0:2];
    logic signed [DFW-1:0] diff_reg;
    logic signed [DFW-1:0] tc_d_reg [0:2];
    logic signed [DFW-1:0] tc_p_reg [0:2];
    logic signed [DFW+etm_pkg::CURVE_W:0] tone_prod;
    logic signed [TW-1:0]  tone_reg;
    logic signed [TW-1:0]  t_sum [0:2];
    logic signed [DW:0]    a_reg [0:2];
    logic [DW-1:0]         um [0:2];
    logic [OB-1:0]         ex [0:2];
    logic [OB-1:0]         res [0:2];

    etm_pkg::pixel_out_t out_pixel_reg;
    logic                out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exposure_reg <= etm_pkg::RST_EXPOSURE;
            max_lum_reg  <= etm_pkg::RST_MAX_LUM;
            curve_reg    <= etm_pkg::RST_CURVE;
            gamma_reg    <= etm_pkg::RST_GAMMA;
        end
        else if (write_en)
        begin
            case (etm_pkg::cfg_reg_t'(write_index))
                etm_pkg::REG_EXPOSURE:  exposure_reg <= write_data;
                etm_pkg::REG_MAX_LUM:   max_lum_reg  <= write_data;
                etm_pkg::REG_CURVE_EXP: curve_reg    <= write_data[etm_pkg::CURVE_W-1:0];
                etm_pkg::REG_GAMMA:     gamma_reg    <= write_data[etm_pkg::GAMMA_W-1:0];
                default: ;
            endcase
        end
    end

    assign p_eff     = (curve_reg > etm_pkg::CURVE_ONE) ? etm_pkg::CURVE_ONE : curve_reg;
    assign g_eff     = (gamma_reg == '0) ? etm_pkg::GAMMA_W'(1) : gamma_reg;
    assign cfg_black = (exposure_reg == '0) || (max_lum_reg == '0);

    // whole pipe moves unless a finished beat is held at the output
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // stage a: weighted channels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else if (en)
            valid_a_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_a_reg[0]  <= in_pixel.red_in;
            c_a_reg[1]  <= in_pixel.green_in;
            c_a_reg[2]  <= in_pixel.blue_in;
            wp_a_reg[0] <= {24'd0, in_pixel.red_in}   * {32'd0, etm_pkg::W_RED};
            wp_a_reg[1] <= {24'd0, in_pixel.green_in} * {32'd0, etm_pkg::W_GREEN};
            wp_a_reg[2] <= {24'd0, in_pixel.blue_in}  * {32'd0, etm_pkg::W_BLUE};
        end
    end

    // stage b: luminance sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_b_reg <= 1'b0;
        else if (en)
            valid_b_reg <= valid_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lum_reg <= etm_pkg::LUMA_W'(wp_a_reg[0]) + etm_pkg::LUMA_W'(wp_a_reg[1])
                     + etm_pkg::LUMA_W'(wp_a_reg[2]);
            for (int j = 0; j < 3; j++)
            begin
                c_b_reg[j] <= c_a_reg[j];
            end
        end
    end

    assign flags_b.valid = valid_b_reg;
    assign flags_b.black = cfg_black || (lum_reg == '0);
    assign flags_b.czero = {c_b_reg[2] == '0, c_b_reg[1] == '0, c_b_reg[0] == '0};
    assign flags_b.sat   = '0;

    // log2 lanes
    etm_log2 #(
        .IN_W (etm_pkg::LUMA_W),
        .FRAC (etm_pkg::INPUT_FRAC_BITS + etm_pkg::LUMA_FRAC)
    ) u_log_lum (
        .clk (clk),
        .en  (en),
        .x   (lum_reg),
        .lg  (lg_l)
    );

    etm_log2 #(
        .IN_W (CW),
        .FRAC (etm_pkg::INPUT_FRAC_BITS)
    ) u_log_max (
        .clk (clk),
        .en  (en),
        .x   (max_lum_reg),
        .lg  (lg_max)
    );

    for (genvar j = 0; j < 3; j++)
    begin : g_log_chan
        etm_log2 #(
            .IN_W (CW),
            .FRAC (etm_pkg::INPUT_FRAC_BITS)
        ) u_log_chan (
            .clk (clk),
            .en  (en),
            .x   (c_b_reg[j]),
            .lg  (lg_c[j])
        );
    end

    etm_delay #(
        .W     (FW),
        .DEPTH (etm_pkg::LOG_LAT)
    ) u_flags_log (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (flags_b),
        .q     (flags_l)
    );

    // stages d, p, t: tone curve in the log domain
    // a nonnegative exponent saturates the channel
    always_comb
    begin
        flags_t_next = flags_p_reg;
        for (int j = 0; j < 3; j++)
        begin
            t_sum[j]             = TW'(tc_p_reg[j]) + tone_reg;
            flags_t_next.sat[j]  = !t_sum[j][TW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_d_reg <= '0;
            flags_p_reg <= '0;
            flags_t_reg <= '0;
        end
        else if (en)
        begin
            flags_d_reg <= flags_l;
            flags_p_reg <= flags_d_reg;
            flags_t_reg <= flags_t_next;
        end
    end

    assign tone_prod = $signed({1'b0, p_eff}) * diff_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= DFW'(lg_l) - DFW'(lg_max);
            tone_reg <= TW'(tone_prod >>> etm_pkg::LOG_FRAC);
            for (int j = 0; j < 3; j++)
            begin
                tc_d_reg[j] <= DFW'(lg_c[j]) - DFW'(lg_l);
                tc_p_reg[j] <= tc_d_reg[j];
                a_reg[j]    <= {t_sum[j], 8'd0};
            end
        end
    end

    // gamma divide and exp2 lanes
    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        etm_div #(
            .DW (DW),
            .GW (etm_pkg::GAMMA_W)
        ) u_div (
            .clk (clk),
            .en  (en),
            .a   (a_reg[j]),
            .g   (g_eff),
            .um  (um[j])
        );

        etm_exp2 #(
            .DW (DW),
            .OB (OB)
        ) u_exp (
            .clk (clk),
            .en  (en),
            .um  (um[j]),
            .res (ex[j])
        );

        assign res[j] = (flags_z.black || flags_z.czero[j]) ? '0
                      : flags_z.sat[j] ? MAXV : ex[j];
    end

    etm_delay #(
        .W     (FW),
        .DEPTH (etm_pkg::DIV_LAT + etm_pkg::EXP_LAT)
    ) u_flags_tail (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (flags_t_reg),
        .q     (flags_z)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= flags_z.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pixel_reg.red_out   <= res[0];
            out_pixel_reg.green_out <= res[1];
            out_pixel_reg.blue_out  <= res[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

    // a held output freezes the middle of the pipe too
    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(flags_t_reg) && $stable(valid_a_reg))
        else $error("pipeline moved while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no beat waiting at the output");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for exponential_tone_map_pixel_unit
// runs pixels through several register settings and compares every output
// beat with a log-domain tone curve predictor, under random idling and stalls
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RAND_PER_SET = 70;

    logic clk;
    logic rst_n;
    logic write_en;
    logic [1:0] write_index;
    logic [etm_pkg::CFG_W-1:0] write_data;
    logic in_valid;
    logic in_stall;
    etm_pkg::pixel_in_t in_pixel;
    logic out_valid;
    logic out_stall;
    etm_pkg::pixel_out_t out_pixel;

    // shadow of the block's registers
    longint unsigned exposure_q;
    longint unsigned lmax_q;
    longint unsigned curve_q;
    longint unsigned gamma_q;

    etm_pkg::pixel_in_t  pixel_queue[$];
    etm_pkg::pixel_out_t display_queue[$];
    int  mismatch_count;
    int  cycle_count;
    bit  no_idle;
    bit  in_taken;

    exponential_tone_map_pixel_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_pixel    (in_pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_pixel   (out_pixel)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint floor_quot(input longint a, input longint b);
        if (a >= 0)
            return a / b;
        return -((-a + b - 1) / b);
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // log2 with 16 fraction bits of a nonzero value with frac fraction bits
    function automatic longint log2_q16(input longint unsigned x, input int frac);
        int msb;
        longint unsigned mant;
        longint fbits;
        msb = 63;
        fbits = 0;
        while (msb > 0 && x[msb] == 1'b0)
            msb--;
        if (msb >= 31)
            mant = x >> (msb - 31);
        else
            mant = x << (31 - msb);
        for (int i = 0; i < etm_pkg::LOG_FRAC; i++)
        begin
            mant = (mant * mant) >> 31;
            fbits = fbits << 1;
            if (mant >= 64'h1_0000_0000)
            begin
                mant = mant >> 1;
                fbits = fbits | 1;
            end
        end
        return longint'(msb - frac) * 65536 + fbits;
    endfunction

    // 2^u for negative u, scaled to the output fraction and saturated
    function automatic logic [etm_pkg::OUTPUT_BITS-1:0] pow2_negative(input longint u);
        longint whole;
        longint fpart;
        longint shift;
        longint unsigned mant;
        longint unsigned root;
        whole = -longint'((unsigned'(-u) + 65535) >> 16);
        fpart = u - whole * 65536;
        mant = 64'd1 << 31;
        root = root_floor(64'd1 << 63);
        for (int i = 1; i <= etm_pkg::LOG_FRAC; i++)
        begin
            if ((fpart >> (etm_pkg::LOG_FRAC - i)) & 1)
                mant = (mant * root) >> 31;
            root = root_floor(root << 31);
        end
        shift = 31 - etm_pkg::OUTPUT_BITS - whole;
        if (shift >= 64)
            return '0;
        mant = mant >> shift;
        if (mant > 64'hFFFF)
            return '1;
        return mant[etm_pkg::OUTPUT_BITS-1:0];
    endfunction

    function automatic etm_pkg::pixel_out_t tone_map(input etm_pkg::pixel_in_t px);
        longint unsigned chan[3];
        longint unsigned luma;
        longint lg_luma, lg_max, tone, p, g, t, u;
        logic [etm_pkg::OUTPUT_BITS-1:0] res[3];
        etm_pkg::pixel_out_t o;
        chan[0] = px.red_in;
        chan[1] = px.green_in;
        chan[2] = px.blue_in;
        res[0] = '0;
        res[1] = '0;
        res[2] = '0;
        luma = chan[0] * etm_pkg::W_RED + chan[1] * etm_pkg::W_GREEN
             + chan[2] * etm_pkg::W_BLUE;
        if (exposure_q != 0 && lmax_q != 0 && luma != 0)
        begin
            p = (curve_q > 65536) ? 65536 : longint'(curve_q);
            g = (gamma_q == 0) ? 1 : longint'(gamma_q);
            lg_luma = log2_q16(luma, etm_pkg::INPUT_FRAC_BITS + etm_pkg::LUMA_FRAC);
            lg_max = log2_q16(lmax_q, etm_pkg::INPUT_FRAC_BITS);
            tone = floor_quot(p * (lg_luma - lg_max), 65536);
            for (int j = 0; j < 3; j++)
            begin
                if (chan[j] != 0)
                begin
                    t = log2_q16(chan[j], etm_pkg::INPUT_FRAC_BITS) - lg_luma + tone;
                    u = floor_quot(t * 256, g);
                    res[j] = (u >= 0) ? '1 : pow2_negative(u);
                end
            end
        end
        o.red_out = res[0];
        o.green_out = res[1];
        o.blue_out = res[2];
        return o;
    endfunction

    function automatic logic [31:0] rand_channel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic etm_pkg::pixel_in_t mk_pixel(input logic [31:0] r,
                                                    input logic [31:0] g,
                                                    input logic [31:0] b);
        etm_pkg::pixel_in_t px;
        px.red_in = r;
        px.green_in = g;
        px.blue_in = b;
        return px;
    endfunction

    task automatic write_reg(input etm_pkg::cfg_reg_t idx,
                             input logic [etm_pkg::CFG_W-1:0] val);
        @(negedge clk);
        write_en <= 1'b1;
        write_index <= idx;
        write_data <= val;
        case (idx)
            etm_pkg::REG_EXPOSURE:  exposure_q = val;
            etm_pkg::REG_MAX_LUM:   lmax_q = val;
            etm_pkg::REG_CURVE_EXP: curve_q = val & 32'h1FFFF;
            etm_pkg::REG_GAMMA:     gamma_q = val & 32'hFFF;
            default:                ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] e, input logic [31:0] m,
                            input logic [31:0] c, input logic [31:0] g);
        write_reg(etm_pkg::REG_EXPOSURE, e);
        write_reg(etm_pkg::REG_MAX_LUM, m);
        write_reg(etm_pkg::REG_CURVE_EXP, c);
        write_reg(etm_pkg::REG_GAMMA, g);
        @(negedge clk);
        write_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pixel_queue.size() != 0 || in_valid || display_queue.size() != 0);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pixel_queue.push_back(mk_pixel(rand_channel(), rand_channel(), rand_channel()));
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pixel_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 28))
            begin
                in_valid <= 1'b1;
                in_pixel <= pixel_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= !no_idle && ($urandom_range(0, 99) < 28);
    end

    // predict on each accepted input beat, check each accepted output beat
    always @(posedge clk)
    begin
        etm_pkg::pixel_out_t want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            display_queue.push_back(tone_map(in_pixel));
        if (rst_n && out_valid && !out_stall)
        begin
            if (display_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output beat %h", out_pixel);
            end
            else
            begin
                want = display_queue.pop_front();
                if (want.red_out !== out_pixel.red_out || want.green_out !== out_pixel.green_out
                    || want.blue_out !== out_pixel.blue_out)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected r %h g %h b %h, got r %h g %h b %h",
                                 want.red_out, want.green_out, want.blue_out,
                                 out_pixel.red_out, out_pixel.green_out, out_pixel.blue_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        write_en = 1'b0;
        write_index = '0;
        write_data = '0;
        in_valid = 1'b0;
        in_pixel = '0;
        out_stall = 1'b0;
        no_idle = 1'b0;
        in_taken = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        exposure_q = 65536;
        lmax_q = 65536;
        curve_q = 32768;
        gamma_q = 563;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed pixels at reset settings
        pixel_queue.push_back(mk_pixel(0, 0, 0));
        pixel_queue.push_back(mk_pixel('1, '1, '1));
        pixel_queue.push_back(mk_pixel(1, 1, 1));
        pixel_queue.push_back(mk_pixel('1, 0, 0));
        pixel_queue.push_back(mk_pixel(0, '1, 0));
        pixel_queue.push_back(mk_pixel(0, 0, '1));
        pixel_queue.push_back(mk_pixel(1, 0, 0));
        pixel_queue.push_back(mk_pixel(0, 0, 1));
        pixel_queue.push_back(mk_pixel(32'h10000, 32'h10000, 32'h10000));
        pixel_queue.push_back(mk_pixel('1, 1, 1));
        pixel_queue.push_back(mk_pixel(1, '1, 32'h8000_0000));
        pixel_queue.push_back(mk_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F));
        queue_random(RAND_PER_SET);
        wait_drained();

        // extremes of every register, one stretch run without idling
        set_regs(0, 65536, 32768, 563);
        pixel_queue.push_back(mk_pixel('1, '1, '1));
        queue_random(10);
        wait_drained();
        set_regs(65536, 0, 32768, 563);
        pixel_queue.push_back(mk_pixel('1, '1, '1));
        queue_random(10);
        wait_drained();
        set_regs('1, '1, 0, 1);
        queue_random(RAND_PER_SET);
        wait_drained();
        set_regs(1, 1, 65536, 2560);
        queue_random(RAND_PER_SET);
        wait_drained();
        set_regs(32'h0003_0000, 32'h0100_0000, 32'h1FFFF, 0);
        queue_random(RAND_PER_SET);
        wait_drained();
        no_idle = 1'b1;
        set_regs(32'h8000, 32'h0040_0000, 32'h10001, 12'hFFF);
        queue_random(RAND_PER_SET);
        wait_drained();
        no_idle = 1'b0;
        set_regs(65536, 32'h0001_8000, 16384, 256);
        queue_random(RAND_PER_SET);
        wait_drained();
        for (int s = 0; s < 6; s++)
        begin
            set_regs($urandom, $urandom >> $urandom_range(0, 31), $urandom_range(0, 65536),
                     $urandom_range(1, 2560));
            queue_random(RAND_PER_SET);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && display_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== exponential_tone_map_pixel_unit.f =====
src/etm_pkg.sv
src/etm_delay.sv
src/etm_log2.sv
src/etm_div.sv
src/etm_exp2.sv
src/exponential_tone_map_pixel_unit.sv
tb/sv/tb.sv
